// ----- rtl/u8v_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 stream validator.
// Used by u8v_decode and utf8_stream_validator; depends on nothing else.
package u8v_pkg;

  // Result field widths and packed stream widths
  localparam int OUT_W     = 32;
  localparam int VERDICT_W = 2;
  localparam int M_TDATA_W = 136;
  localparam int S_TDATA_W = 8;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // Register word index, taken from paddr[2]
  localparam logic REG_MAX_BYTES = 1'b0;
  localparam logic [APB_DW-1:0] MAX_BYTES_RST = 32'd8388608;

  // Byte classes
  localparam logic [7:0] B_TAB      = 8'h09;
  localparam logic [7:0] B_LF       = 8'h0a;
  localparam logic [7:0] B_CR       = 8'h0d;
  localparam logic [7:0] B_SPACE    = 8'h20;
  localparam logic [7:0] B_DEL      = 8'h7f;
  localparam logic [7:0] B_CONT_LO  = 8'h80;
  localparam logic [7:0] B_CONT_HI  = 8'hbf;
  localparam logic [7:0] B_LEAD2_LO = 8'hc2;
  localparam logic [7:0] B_LEAD2_HI = 8'hdf;
  localparam logic [7:0] B_LEAD3_LO = 8'he0;
  localparam logic [7:0] B_LEAD3_SR = 8'hed;
  localparam logic [7:0] B_LEAD3_HI = 8'hef;
  localparam logic [7:0] B_LEAD4_LO = 8'hf0;
  localparam logic [7:0] B_LEAD4_HI = 8'hf4;
  localparam logic [7:0] B_A0       = 8'ha0;
  localparam logic [7:0] B_90       = 8'h90;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_VALID     = 2'd0,
    VERDICT_INVALID   = 2'd1,
    VERDICT_TOO_LARGE = 2'd2
  } verdict_e;

  // Constraint on the first continuation byte of a sequence
  typedef enum logic [2:0] {
    RULE_NONE  = 3'd0,
    RULE_GE_A0 = 3'd1,
    RULE_LT_A0 = 3'd2,
    RULE_GE_90 = 3'd3,
    RULE_LT_90 = 3'd4
  } rule_e;

  typedef struct packed {
    logic [1:0] tails_left;
    rule_e      second_rule;
    logic       at_second;
  } dec_state_t;

  typedef struct packed {
    dec_state_t nxt;
    logic       err;        // encoding error on this byte
    logic       err_lead;   // error lies at this byte itself
    logic       seq_start;  // this byte opens a multibyte sequence
  } dec_result_t;

endpackage

// ----- rtl/u8v_decode.sv -----
`timescale 1ns / 1ps
// One-byte step of the strict UTF-8 decoder: next sequence state and error flags.
// Depends on u8v_pkg.
module u8v_decode import u8v_pkg::*; (
  input  dec_state_t  cur_i,
  input  logic [7:0]  byte_i,
  output dec_result_t res_o
);

  logic second_ok;

  // Check the first continuation byte against the lead byte's rule
  always_comb begin
    case (cur_i.second_rule)
      RULE_GE_A0: second_ok = (byte_i >= B_A0);
      RULE_LT_A0: second_ok = (byte_i <  B_A0);
      RULE_GE_90: second_ok = (byte_i >= B_90);
      RULE_LT_90: second_ok = (byte_i <  B_90);
      default:    second_ok = 1'b1;
    endcase
  end

  // Classify lead bytes and advance through continuation bytes
  always_comb begin
    res_o.nxt       = cur_i;
    res_o.err       = 1'b0;
    res_o.err_lead  = 1'b0;
    res_o.seq_start = 1'b0;
    if (cur_i.tails_left == 2'd0) begin
      if (byte_i < B_CONT_LO) begin
        if ((byte_i < B_SPACE && byte_i != B_TAB && byte_i != B_LF && byte_i != B_CR) ||
            byte_i == B_DEL) begin
          res_o.err      = 1'b1;
          res_o.err_lead = 1'b1;
        end
      end else if (byte_i >= B_LEAD2_LO && byte_i <= B_LEAD2_HI) begin
        res_o.nxt.tails_left  = 2'd1;
        res_o.nxt.second_rule = RULE_NONE;
        res_o.nxt.at_second   = 1'b1;
        res_o.seq_start       = 1'b1;
      end else if (byte_i >= B_LEAD3_LO && byte_i <= B_LEAD3_HI) begin
        res_o.nxt.tails_left  = 2'd2;
        res_o.nxt.second_rule = (byte_i == B_LEAD3_LO) ? RULE_GE_A0 :
                                (byte_i == B_LEAD3_SR) ? RULE_LT_A0 : RULE_NONE;
        res_o.nxt.at_second   = 1'b1;
        res_o.seq_start       = 1'b1;
      end else if (byte_i >= B_LEAD4_LO && byte_i <= B_LEAD4_HI) begin
        res_o.nxt.tails_left  = 2'd3;
        res_o.nxt.second_rule = (byte_i == B_LEAD4_LO) ? RULE_GE_90 :
                                (byte_i == B_LEAD4_HI) ? RULE_LT_90 : RULE_NONE;
        res_o.nxt.at_second   = 1'b1;
        res_o.seq_start       = 1'b1;
      end else begin
        res_o.err      = 1'b1;
        res_o.err_lead = 1'b1;
      end
    end else begin
      if (byte_i < B_CONT_LO || byte_i > B_CONT_HI || (cur_i.at_second && !second_ok)) begin
        res_o.err            = 1'b1;
        res_o.nxt.tails_left = 2'd0;
      end else begin
        res_o.nxt.at_second  = 1'b0;
        res_o.nxt.tails_left = cur_i.tails_left - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/utf8_stream_validator.sv -----
`timescale 1ns / 1ps
// Strict UTF-8 document validator with byte and line counting.
// A last byte is held in the input register, then its verdict loads the result register.
// Throughput: one byte per cycle while no stalled result holds a last byte.
// A stalled result holds only the last byte of the next document; other bytes keep flowing.
// Reset clears all document state and sets max_bytes to 8388608.
module utf8_stream_validator import u8v_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Byte stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic                 s_axis_tlast_i,   // last
  // Verdict stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,   // verdict, error_line, error_offset,
                                                 // line_count, byte_count, zero pad
  // Configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  localparam int CMP_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == '1) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] hi;
    hi = v >> OUT_W;
    clamp_out = (hi != '0) ? '1 : OUT_W'(v);
  endfunction

  // Configuration register
  logic [APB_DW-1:0] max_bytes_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_BYTES) ? max_bytes_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MAX_BYTES_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_BYTES) begin
      max_bytes_q <= pwdata;
    end
  end

  // Input register and handshake
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic       advance;

  assign advance         = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i[7:0];
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Document state
  dec_state_t            dec_q, dec_d;
  logic                  err_seen_q, err_seen_d;
  logic [COUNT_BITS-1:0] err_off_q, err_off_d;
  logic [COUNT_BITS-1:0] err_line_q, err_line_d;
  logic [COUNT_BITS-1:0] seq_start_q, seq_start_d;
  logic [COUNT_BITS-1:0] bytes_q, bytes_d;
  logic [COUNT_BITS-1:0] lines_q, lines_d;
  dec_result_t           dec_res;

  u8v_decode u_decode (
    .cur_i  (dec_q),
    .byte_i (in_byte_q),
    .res_o  (dec_res)
  );

  // Result register contents
  verdict_e         verdict_d;
  logic [OUT_W-1:0] res_line_d, res_off_d, res_lcount_d, res_bcount_d;
  logic             err_now;
  logic [COUNT_BITS-1:0] seq_next, bytes_next, lines_next, err_off_now, err_line_now;

  // Step the decoder and counters for the registered byte
  always_comb begin
    seq_next     = (!err_seen_q && dec_res.seq_start) ? bytes_q : seq_start_q;
    err_now      = !err_seen_q &&
                   (dec_res.err || (in_last_q && dec_res.nxt.tails_left != 2'd0));
    err_off_now  = dec_res.err_lead ? bytes_q : seq_next;
    err_line_now = sat_inc(lines_q);
    bytes_next   = sat_inc(bytes_q);
    lines_next   = (in_byte_q == B_LF) ? sat_inc(lines_q) : lines_q;

    // Form the verdict
    res_bcount_d = clamp_out(bytes_next);
    res_line_d   = '0;
    res_off_d    = '0;
    res_lcount_d = '0;
    if (CMP_W'(bytes_next) > CMP_W'(max_bytes_q)) begin
      verdict_d  = VERDICT_TOO_LARGE;
      res_line_d = OUT_W'(1);
    end else if (err_seen_q || err_now) begin
      verdict_d  = VERDICT_INVALID;
      res_line_d = err_seen_q ? clamp_out(err_line_q) : clamp_out(err_line_now);
      res_off_d  = err_seen_q ? clamp_out(err_off_q)  : clamp_out(err_off_now);
    end else begin
      verdict_d    = VERDICT_VALID;
      res_lcount_d = (in_byte_q != B_LF) ? clamp_out(sat_inc(lines_next))
                                         : clamp_out(lines_next);
    end

    // Next document state; clear after the last byte
    dec_d       = dec_q;
    err_seen_d  = err_seen_q;
    err_off_d   = err_off_q;
    err_line_d  = err_line_q;
    seq_start_d = seq_start_q;
    bytes_d     = bytes_q;
    lines_d     = lines_q;
    if (advance) begin
      if (in_last_q) begin
        dec_d       = '{tails_left: 2'd0, second_rule: RULE_NONE, at_second: 1'b0};
        err_seen_d  = 1'b0;
        err_off_d   = '0;
        err_line_d  = '0;
        seq_start_d = '0;
        bytes_d     = '0;
        lines_d     = '0;
      end else begin
        if (!err_seen_q) begin
          dec_d = dec_res.nxt;
        end
        if (err_now) begin
          err_seen_d = 1'b1;
          err_off_d  = err_off_now;
          err_line_d = err_line_now;
        end
        seq_start_d = seq_next;
        bytes_d     = bytes_next;
        lines_d     = lines_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q       <= '{tails_left: 2'd0, second_rule: RULE_NONE, at_second: 1'b0};
      err_seen_q  <= 1'b0;
      err_off_q   <= '0;
      err_line_q  <= '0;
      seq_start_q <= '0;
      bytes_q     <= '0;
      lines_q     <= '0;
    end else begin
      dec_q       <= dec_d;
      err_seen_q  <= err_seen_d;
      err_off_q   <= err_off_d;
      err_line_q  <= err_line_d;
      seq_start_q <= seq_start_d;
      bytes_q     <= bytes_d;
      lines_q     <= lines_d;
    end
  end

  // Result register: load on the last byte, drop when taken
  logic [M_TDATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_data_q <= {6'b0, res_bcount_d, res_lcount_d, res_off_d, res_line_d, verdict_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ----- dv/utf8_stream_validator_tb.sv -----
`timescale 1ns / 1ps
// Testbench for utf8_stream_validator: streams byte documents with random gaps and
// stalls, and checks every verdict against a cycle-free model of the decoder.
// Depends on u8v_pkg and the utf8_stream_validator RTL.
module utf8_stream_validator_tb;
  import u8v_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_WAIT    = 4;
  localparam int RANDOM_BYTES = 540;
  localparam int PHASES       = 4;
  localparam logic [APB_AW-1:0] MAX_BYTES_ADDR = {REG_MAX_BYTES, 2'b00};
  localparam logic [31:0] LIMIT_NONE = 32'hffff_ffff;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;
  typedef enum logic [1:0] {CHAR_WHOLE, CHAR_CUT, CHAR_BAD_SECOND} char_form_e;

  typedef struct {
    verdict_e    verdict;
    logic [31:0] err_line;
    logic [31:0] err_offset;
    logic [31:0] line_count;
    logic [31:0] byte_count;
  } verdict_rec_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;   // [7:0] data_byte
  logic                 s_axis_tlast_i;   // last
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;   // verdict, error_line, error_offset,
                                          // line_count, byte_count, zero pad
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  utf8_stream_validator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Decoder model state
  logic [1:0]  tails_left;
  rule_e       first_rule;
  logic        at_first_tail;
  logic        err_seen;
  logic [31:0] err_offset;
  logic [31:0] err_line;
  logic [31:0] seq_start;
  logic [31:0] byte_cnt;
  logic [31:0] lf_cnt;
  logic [31:0] max_bytes_cfg;

  verdict_rec_t pending_verdicts[$];
  verdict_rec_t want_v;
  logic [7:0]   doc_buf[$];

  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       random_bytes_sent;
  int       burst_left;
  bit       tx_gaps;
  int       hold_req;
  int       hold_seen;
  int       hold_left;
  int       stall_left;
  int       rx_phase;
  rx_mode_e rx_mode;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("utf8_stream_validator test failed");
      $finish;
    end
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hffff_ffff) ? v : v + 32'd1;
  endfunction

  function automatic logic first_tail_ok(input logic [7:0] b);
    case (first_rule)
      RULE_GE_A0: return b >= B_A0;
      RULE_LT_A0: return b < B_A0;
      RULE_GE_90: return b >= B_90;
      RULE_LT_90: return b < B_90;
      default:    return 1'b1;
    endcase
  endfunction

  task automatic note_error(input logic [31:0] at);
    err_seen   = 1'b1;
    err_offset = at;
    err_line   = sat_inc(lf_cnt);
    tails_left = 2'd0;
  endtask

  task automatic clear_document();
    tails_left    = 2'd0;
    first_rule    = RULE_NONE;
    at_first_tail = 1'b0;
    err_seen      = 1'b0;
    err_offset    = '0;
    err_line      = '0;
    seq_start     = '0;
    byte_cnt      = '0;
    lf_cnt        = '0;
  endtask

  // Advance the model by one accepted byte; queue the verdict on a last byte
  task automatic track_byte(input logic [7:0] b, input logic is_last);
    verdict_rec_t v;
    logic [1:0]   need;
    rule_e        r;
    need = 2'd0;
    r    = RULE_NONE;
    if (!err_seen) begin
      if (tails_left == 2'd0) begin
        if (b < B_CONT_LO) begin
          if ((b < B_SPACE && b != B_TAB && b != B_LF && b != B_CR) || b == B_DEL)
            note_error(byte_cnt);
        end else if (b >= B_LEAD2_LO && b <= B_LEAD2_HI) begin
          need = 2'd1;
        end else if (b >= B_LEAD3_LO && b <= B_LEAD3_HI) begin
          need = 2'd2;
          if (b == B_LEAD3_LO) r = RULE_GE_A0;
          else if (b == B_LEAD3_SR) r = RULE_LT_A0;
        end else if (b >= B_LEAD4_LO && b <= B_LEAD4_HI) begin
          need = 2'd3;
          if (b == B_LEAD4_LO) r = RULE_GE_90;
          else if (b == B_LEAD4_HI) r = RULE_LT_90;
        end else begin
          note_error(byte_cnt);
        end
        if (need != 2'd0) begin
          tails_left    = need;
          first_rule    = r;
          seq_start     = byte_cnt;
          at_first_tail = 1'b1;
        end
      end else if (b < B_CONT_LO || b > B_CONT_HI || (at_first_tail && !first_tail_ok(b))) begin
        note_error(seq_start);
      end else begin
        at_first_tail = 1'b0;
        tails_left    = tails_left - 2'd1;
      end
    end
    // A sequence cut short by the end of the document fails at its lead byte
    if (is_last && !err_seen && tails_left != 2'd0) note_error(seq_start);
    byte_cnt = sat_inc(byte_cnt);
    if (b == B_LF) lf_cnt = sat_inc(lf_cnt);
    if (is_last) begin
      v.byte_count = byte_cnt;
      if (byte_cnt > max_bytes_cfg) begin
        v.verdict    = VERDICT_TOO_LARGE;
        v.err_line   = 32'd1;
        v.err_offset = '0;
        v.line_count = '0;
      end else if (err_seen) begin
        v.verdict    = VERDICT_INVALID;
        v.err_line   = err_line;
        v.err_offset = err_offset;
        v.line_count = '0;
      end else begin
        v.verdict    = VERDICT_VALID;
        v.err_line   = '0;
        v.err_offset = '0;
        v.line_count = (b != B_LF) ? sat_inc(lf_cnt) : lf_cnt;
      end
      pending_verdicts = {pending_verdicts, v};
      clear_document();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each verdict with the oldest pending one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unrequested verdict, expected none, actual %h", $time, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want_v = pending_verdicts.pop_front();
        check_field("verdict", {30'd0, want_v.verdict}, {30'd0, m_axis_tdata_o[1:0]});
        check_field("error_line", want_v.err_line, m_axis_tdata_o[33:2]);
        check_field("error_offset", want_v.err_offset, m_axis_tdata_o[65:34]);
        check_field("line_count", want_v.line_count, m_axis_tdata_o[97:66]);
        check_field("byte_count", want_v.byte_count, m_axis_tdata_o[129:98]);
        check_field("pad", 32'd0, {26'd0, m_axis_tdata_o[135:130]});
      end
    end
  end

  // Drive verdict-side ready: long hold-off on request, else the current stall mode
  initial begin
    m_axis_tready_i = 1'b0;
    hold_seen  = 0;
    hold_left  = 0;
    stall_left = 0;
    rx_phase   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: m_axis_tready_i <= 1'b1;
          RX_RANDOM: begin
            if ($urandom_range(0, 3) == 0) begin
              stall_left = $urandom_range(0, 11);
              m_axis_tready_i <= 1'b0;
            end else begin
              m_axis_tready_i <= 1'b1;
            end
          end
          default: begin
            m_axis_tready_i <= (rx_phase % 7) < 4;
            rx_phase++;
          end
        endcase
      end
    end
  end

  // Send one byte request, with a random gap between bursts when tx_gaps is set
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    if (tx_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(1, 6);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= is_last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    track_byte(b, is_last);
  endtask

  task automatic send_document();
    int i;
    for (i = 0; i < doc_buf.size(); i++) send_byte(doc_buf[i], i == doc_buf.size() - 1);
    random_bytes_sent += doc_buf.size();
  endtask

  // Drop valid, wait for every verdict, then let the pipeline settle
  task automatic wait_for_verdicts();
    s_axis_tvalid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_BYTES_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    max_bytes_cfg = value;
  endtask

  task automatic reg_read(output logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MAX_BYTES_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limit(input logic [31:0] value);
    logic [31:0] got;
    wait_for_verdicts();
    reg_write(value);
    // Idle between the write and the read-back
    @(posedge clk_i);
    reg_read(got);
    check_field("max_bytes", value, got);
  endtask

  // Append one code point: whole, cut short, or with an out-of-range first tail
  task automatic push_char(input char_form_e form);
    int         kind;
    int         len;
    int         keep;
    int         lo;
    int         hi;
    int         i;
    logic [7:0] lead;
    kind = (form == CHAR_WHOLE) ? $urandom_range(0, 7) : $urandom_range(5, 7);
    if (form == CHAR_BAD_SECOND && kind == 5) kind = 6;
    lo  = 'h80;
    hi  = 'hbf;
    len = 1;
    case (kind)
      4: begin
        case ($urandom_range(0, 3))
          0:       lead = B_TAB;
          1:       lead = B_CR;
          default: lead = B_LF;
        endcase
      end
      5: begin
        len  = 2;
        lead = 8'($urandom_range('hc2, 'hdf));
      end
      6: begin
        len = 3;
        if (form == CHAR_BAD_SECOND) begin
          if ($urandom_range(0, 1) == 0) begin
            lead = B_LEAD3_LO;
            hi   = 'h9f;
          end else begin
            lead = B_LEAD3_SR;
            lo   = 'ha0;
          end
        end else begin
          lead = 8'($urandom_range('he0, 'hef));
          if (lead == B_LEAD3_LO) lo = 'ha0;
          else if (lead == B_LEAD3_SR) hi = 'h9f;
        end
      end
      7: begin
        len = 4;
        if (form == CHAR_BAD_SECOND) begin
          if ($urandom_range(0, 1) == 0) begin
            lead = B_LEAD4_LO;
            hi   = 'h8f;
          end else begin
            lead = B_LEAD4_HI;
            lo   = 'h90;
          end
        end else begin
          lead = 8'($urandom_range('hf0, 'hf4));
          if (lead == B_LEAD4_LO) lo = 'h90;
          else if (lead == B_LEAD4_HI) hi = 'h8f;
        end
      end
      default: lead = 8'($urandom_range('h20, 'h7e));
    endcase
    keep = (form == CHAR_CUT) ? $urandom_range(1, len - 1) : len;
    doc_buf = {doc_buf, lead};
    if (keep > 1) doc_buf = {doc_buf, 8'($urandom_range(lo, hi))};
    for (i = 2; i < keep; i++) doc_buf = {doc_buf, 8'($urandom_range('h80, 'hbf))};
  endtask

  // Build a document: well-formed text, some of it corrupted, some pure noise
  task automatic send_random_document();
    int pick;
    int units;
    int pos;
    int i;
    doc_buf.delete();
    pick  = $urandom_range(0, 99);
    units = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
    if (pick < 10) begin
      for (i = 0; i < units; i++) doc_buf = {doc_buf, 8'($urandom_range(0, 255))};
    end else begin
      for (i = 0; i < units; i++) push_char(CHAR_WHOLE);
      if (pick < 35) begin
        pos = $urandom_range(0, doc_buf.size() - 1);
        doc_buf[pos] = 8'($urandom_range(0, 255));
      end else if (pick < 47) begin
        push_char(CHAR_CUT);
      end else if (pick < 57) begin
        push_char(CHAR_BAD_SECOND);
        push_char(CHAR_WHOLE);
      end
    end
    send_document();
  endtask

  task automatic test_register_access();
    logic [31:0] got;
    reg_read(got);
    check_field("max_bytes reset", MAX_BYTES_RST, got);
    set_limit(32'd0);
    set_limit(LIMIT_NONE);
  endtask

  task automatic test_directed_documents();
    set_limit(LIMIT_NONE);
    // Plain text ending in a newline
    doc_buf = '{8'h41, 8'h0a};
    send_document();
    // Bad lead at offset 0, later errors ignored
    doc_buf = '{8'hff, 8'h00};
    send_document();
    // Sequence cut short by the end, on the second line
    doc_buf = '{8'h0a, 8'he1, 8'h80};
    send_document();
    // Overlong three-byte form
    doc_buf = '{8'he0, 8'h9f, 8'h80};
    send_document();
    // Highest code point, then tab and CR
    doc_buf = '{8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'h09, 8'h0d};
    send_document();
    // Size over the limit wins over a bad byte
    set_limit(32'd2);
    doc_buf = '{8'hc0, 8'h41, 8'h42};
    send_document();
    set_limit(32'd0);
    doc_buf = '{8'h7f};
    send_document();
  endtask

  task automatic test_result_backpressure();
    int i;
    set_limit(LIMIT_NONE);
    tx_gaps = 1'b0;
    hold_req <= hold_req + 1;
    for (i = 0; i < 12; i++) send_random_document();
    wait_for_verdicts();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_documents();
    int phase;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          set_limit(LIMIT_NONE);
          rx_mode <= RX_RANDOM;
          tx_gaps = 1'b1;
        end
        1: begin
          set_limit(32'($urandom_range(4, 24)));
          rx_mode <= RX_PATTERN;
          tx_gaps = 1'b1;
        end
        2: begin
          set_limit(MAX_BYTES_RST);
          rx_mode <= RX_ALWAYS;
          tx_gaps = 1'b0;
        end
        default: begin
          set_limit(32'($urandom_range(8, 40)));
          rx_mode <= RX_RANDOM;
          tx_gaps = 1'b1;
        end
      endcase
      random_bytes_sent = 0;
      while (random_bytes_sent < RANDOM_BYTES / PHASES) send_random_document();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    tx_gaps         = 1'b1;
    burst_left      = 0;
    hold_req        = 0;
    rx_mode         = RX_RANDOM;
    max_bytes_cfg   = MAX_BYTES_RST;
    clear_document();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_directed_documents();
    test_result_backpressure();
    test_random_documents();

    wait_for_verdicts();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("utf8_stream_validator test passed");
    end else begin
      $display("utf8_stream_validator test failed");
    end
    $finish;
  end

endmodule
